// ===== src/cst_pkg.sv =====
// shared types and constants for the class slot table
package cst_pkg;

    localparam int unsigned CODE_W      = 8;
    localparam int unsigned SLOT_OUT_W  = 3;
    localparam int unsigned COUNT_OUT_W = 16;

    typedef struct packed {
        logic [CODE_W-1:0] item_color;
        logic [CODE_W-1:0] item_shape;
    } item_t;

    typedef struct packed {
        logic [SLOT_OUT_W-1:0]  slot_index;
        logic                   was_hit;
        logic                   was_added;
        logic                   table_full;
        logic [COUNT_OUT_W-1:0] slot_count;
    } result_t;

    // outcome of one lookup against the table
    typedef struct packed {
        logic hit;
        logic added;
        logic full;
    } lookup_t;

endpackage

// ===== src/cst_search.sv =====
// parallel compare of a key against all entries, lowest match and lowest free slot
module cst_search #(
    parameter int unsigned NUM_SLOTS = 8,
    parameter int unsigned IDX_W     = 3
) (
    input  logic [NUM_SLOTS-1:0]                    valid,
    input  logic [NUM_SLOTS-1:0][cst_pkg::CODE_W-1:0] colors,
    input  logic [NUM_SLOTS-1:0][cst_pkg::CODE_W-1:0] shapes,
    input  cst_pkg::item_t                          key,
    output cst_pkg::lookup_t                        look,
    output logic [IDX_W-1:0]                        slot
);

    logic [NUM_SLOTS-1:0] match_vec;
    logic [IDX_W-1:0]     match_idx;
    logic [IDX_W-1:0]     free_idx;

    always_comb
    begin
        for (int k = 0; k < NUM_SLOTS; k++)
        begin
            match_vec[k] = valid[k] && (colors[k] == key.item_color)
                                    && (shapes[k] == key.item_shape);
        end
    end

    // scan from the top so the lowest index wins
    always_comb
    begin
        match_idx = '0;
        free_idx  = '0;
        for (int k = NUM_SLOTS - 1; k >= 0; k--)
        begin
            if (match_vec[k])
            begin
                match_idx = IDX_W'(k);
            end
            if (!valid[k])
            begin
                free_idx = IDX_W'(k);
            end
        end
    end

    always_comb
    begin
        look.hit   = |match_vec;
        look.added = !look.hit && !(&valid);
        look.full  = !look.hit && (&valid);
        priority if (look.hit)
        begin
            slot = match_idx;
        end
        else if (look.added)
        begin
            slot = free_idx;
        end
        else
        begin
            slot = '0;
        end
    end

endmodule

// ===== src/cst_table.sv =====
// entry storage with per-item update: count bump on hit, claim on miss while a slot is free
module cst_table #(
    parameter int unsigned NUM_SLOTS  = 8,
    parameter int unsigned COUNT_BITS = 16,
    parameter int unsigned IDX_W      = 3
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  upd,
    input  cst_pkg::item_t        key,
    output cst_pkg::lookup_t      look,
    output logic [IDX_W-1:0]      slot,
    output logic [COUNT_BITS-1:0] count
);

    logic [NUM_SLOTS-1:0]                      valid_reg;
    logic [NUM_SLOTS-1:0][cst_pkg::CODE_W-1:0] color_reg;
    logic [NUM_SLOTS-1:0][cst_pkg::CODE_W-1:0] shape_reg;
    logic [NUM_SLOTS-1:0][COUNT_BITS-1:0]      count_reg;
    logic [COUNT_BITS-1:0]                     cur_count;

    cst_search #(
        .NUM_SLOTS (NUM_SLOTS),
        .IDX_W     (IDX_W)
    ) u_search (
        .valid  (valid_reg),
        .colors (color_reg),
        .shapes (shape_reg),
        .key    (key),
        .look   (look),
        .slot   (slot)
    );

    assign cur_count = count_reg[slot];

    // saturating bump on hit, one on claim, zero when full
    always_comb
    begin
        priority if (look.hit)
        begin
            count = (&cur_count) ? cur_count : cur_count + COUNT_BITS'(1);
        end
        else if (look.added)
        begin
            count = COUNT_BITS'(1);
        end
        else
        begin
            count = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (upd && look.added)
        begin
            valid_reg[slot] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (upd && (look.hit || look.added))
        begin
            count_reg[slot] <= count;
        end
        if (upd && look.added)
        begin
            color_reg[slot] <= key.item_color;
            shape_reg[slot] <= key.item_shape;
        end
    end

endmodule

// ===== src/class_slot_table_top.sv =====
// top level of the class slot table: input register, table, result register
//
// usage
//   - an item (color code, shape code) is transferred at a rising edge with
//     start high and busy low; busy is always low, so one item per cycle
//   - the item is held in an input register while all table entries are
//     compared with it in parallel and the table is updated
//   - the result is registered and shown for exactly one cycle with done high
//   - the start transfer loads item_reg and sets pend_reg; the result is
//     then registered into result_reg along with done_reg, so done is high
//     while the result is shown; throughput one item per clock, set by the
//     single compare-and-update pass over the flops
//   - a hit bumps the lowest matching entry's count (saturating); a miss
//     claims the lowest free entry with count one; with no match and no
//     free entry table_full is reported and the table is left as it was
//   - reset clears every entry's valid bit and drops any item in flight
//   - the receiver cannot stall; done is high for a single cycle per result
//   - slot_index carries the low 3 bits of the entry index, slot_count the
//     low 16 bits of the count
module class_slot_table_top #(
    parameter int unsigned NUM_SLOTS  = 8,
    parameter int unsigned COUNT_BITS = 16
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  cst_pkg::item_t   item,
    output logic             done,
    output cst_pkg::result_t result
);

    localparam int unsigned IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

    // input stage
    logic             pend_reg;
    cst_pkg::item_t   item_reg;

    // table outcome for the held item
    cst_pkg::lookup_t      look;
    logic [IDX_W-1:0]      slot;
    logic [COUNT_BITS-1:0] count;

    // widened views so the output fields can be cut at any parameter value
    logic [IDX_W+cst_pkg::SLOT_OUT_W-1:0]       slot_wide;
    logic [COUNT_BITS+cst_pkg::COUNT_OUT_W-1:0] count_wide;

    // result stage
    logic             done_reg;
    cst_pkg::result_t result_reg;
    cst_pkg::result_t result_next;

    // every cycle completes one item, so nothing ever holds the sender off
    assign busy = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= 1'b0;
        end
        else
        begin
            pend_reg <= start && !busy;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy)
        begin
            item_reg <= item;
        end
    end

    cst_table #(
        .NUM_SLOTS  (NUM_SLOTS),
        .COUNT_BITS (COUNT_BITS),
        .IDX_W      (IDX_W)
    ) u_table (
        .clk   (clk),
        .rst_n (rst_n),
        .upd   (pend_reg),
        .key   (item_reg),
        .look  (look),
        .slot  (slot),
        .count (count)
    );

    assign slot_wide  = {{cst_pkg::SLOT_OUT_W{1'b0}}, slot};
    assign count_wide = {{cst_pkg::COUNT_OUT_W{1'b0}}, count};

    always_comb
    begin
        result_next.slot_index = slot_wide[cst_pkg::SLOT_OUT_W-1:0];
        result_next.was_hit    = look.hit;
        result_next.was_added  = look.added;
        result_next.table_full = look.full;
        result_next.slot_count = count_wide[cst_pkg::COUNT_OUT_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= pend_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pend_reg)
        begin
            result_reg <= result_next;
        end
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule
